// ===== design/lre_pkg.sv =====
package lre_pkg;

    localparam int SQRT_STEPS   = 32;
    localparam int CORDIC_STEPS = 23;
    localparam int X_W          = 60;
    localparam int ANG_W        = 26;
    localparam int REM_W        = 34;
    localparam int NUM_W        = 28;
    localparam int MAX_RINGS_DEF = 64;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 31;

    localparam logic [CFG_IDX_W-1:0] REG_MIN_RANGE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_RANGE    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LINE_COUNT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SENSOR_MODEL = 3'd3;

    localparam logic [30:0] MIN_RANGE_RST  = 31'd196608;
    localparam logic [30:0] MAX_RANGE_RST  = 31'd2293760;
    localparam logic [7:0]  LINE_COUNT_RST = 8'd64;

    localparam logic [7:0] LINES_16 = 8'd16;
    localparam logic [7:0] LINES_32 = 8'd32;
    localparam logic [7:0] LINES_64 = 8'd64;

    localparam logic [2:0] ST_KEPT        = 3'd0;
    localparam logic [2:0] ST_NOT_FINITE  = 3'd1;
    localparam logic [2:0] ST_RANGE       = 3'd2;
    localparam logic [2:0] ST_ELEVATION   = 3'd3;
    localparam logic [2:0] ST_UNSUPPORTED = 3'd4;

    typedef struct packed {
        logic       valid;
        logic [2:0] status;
    } t_ctl;

    typedef struct packed {
        t_ctl               ctl;
        logic signed [31:0] z;
        logic [63:0]        rad;
        logic [REM_W-1:0]   rem;
        logic [31:0]        root;
    } t_sqrt_stage;

    typedef struct packed {
        t_ctl                     ctl;
        logic                     zero;
        logic                     zneg;
        logic signed [X_W-1:0]    xv;
        logic signed [X_W-1:0]    yv;
        logic signed [ANG_W-1:0]  ang;
    } t_cordic_stage;

    // atan(2^-i) in degrees, Q16.16, rounded.
    function automatic logic signed [ANG_W-1:0] atan_q16(input int i);
        logic signed [ANG_W-1:0] v;
        case (i)
            0:       v = 26'sd2949120;
            1:       v = 26'sd1740967;
            2:       v = 26'sd919879;
            3:       v = 26'sd466945;
            4:       v = 26'sd234379;
            5:       v = 26'sd117304;
            6:       v = 26'sd58666;
            7:       v = 26'sd29335;
            8:       v = 26'sd14668;
            9:       v = 26'sd7334;
            10:      v = 26'sd3667;
            11:      v = 26'sd1833;
            12:      v = 26'sd917;
            13:      v = 26'sd458;
            14:      v = 26'sd229;
            15:      v = 26'sd115;
            16:      v = 26'sd57;
            17:      v = 26'sd29;
            18:      v = 26'sd14;
            19:      v = 26'sd7;
            20:      v = 26'sd4;
            21:      v = 26'sd2;
            22:      v = 26'sd1;
            default: v = 26'sd0;
        endcase
        return v;
    endfunction

endpackage

// ===== design/lre_sqrt_cell.sv =====
// One step of a restoring square root: two radicand bits in, one root bit out.
module lre_sqrt_cell (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_adv,
    input  lre_pkg::t_sqrt_stage i_d,
    output lre_pkg::t_sqrt_stage o_q
);
    lre_pkg::t_sqrt_stage r_q, n_q;
    logic [lre_pkg::REM_W+1:0] w_cur, w_trial;

    always_comb begin
        w_cur   = {i_d.rem, i_d.rad[63:62]};
        w_trial = {2'b00, i_d.root, 2'b01};
        n_q     = i_d;
        n_q.rad = {i_d.rad[61:0], 2'b00};
        if (w_cur >= w_trial) begin
            n_q.rem  = lre_pkg::REM_W'(w_cur - w_trial);
            n_q.root = {i_d.root[30:0], 1'b1};
        end else begin
            n_q.rem  = lre_pkg::REM_W'(w_cur);
            n_q.root = {i_d.root[30:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q.ctl.valid <= 1'b0;
        end else if (i_adv) begin
            r_q <= n_q;
        end
    end

    assign o_q = r_q;
endmodule

// ===== design/lre_cordic_cell.sv =====
// One vectoring rotation step; SHIFT is this cell's place in the chain.
module lre_cordic_cell #(
    parameter int SHIFT = 0
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_adv,
    input  lre_pkg::t_cordic_stage i_d,
    output lre_pkg::t_cordic_stage o_q
);
    lre_pkg::t_cordic_stage r_q, n_q;
    logic signed [lre_pkg::X_W-1:0] w_xs, w_ys;

    always_comb begin
        w_xs = $signed(i_d.xv) >>> SHIFT;
        w_ys = $signed(i_d.yv) >>> SHIFT;
        n_q  = i_d;
        if (!i_d.yv[lre_pkg::X_W-1]) begin
            n_q.xv  = i_d.xv + w_ys;
            n_q.yv  = i_d.yv - w_xs;
            n_q.ang = i_d.ang + lre_pkg::atan_q16(SHIFT);
        end else begin
            n_q.xv  = i_d.xv - w_ys;
            n_q.yv  = i_d.yv + w_xs;
            n_q.ang = i_d.ang - lre_pkg::atan_q16(SHIFT);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q.ctl.valid <= 1'b0;
        end else if (i_adv) begin
            r_q <= n_q;
        end
    end

    assign o_q = r_q;
endmodule

// ===== design/lre_ring_map.sv =====
// Maps the elevation angle to a ring index in two registered stages.
module lre_ring_map (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_adv,
    input  logic [7:0]             i_line_count,
    input  lre_pkg::t_cordic_stage i_d,
    output logic                   o_valid,
    output logic                   o_keep,
    output logic [5:0]             o_ring,
    output logic [2:0]             o_status
);
    localparam int NW = lre_pkg::NUM_W;

    logic signed [lre_pkg::ANG_W-1:0] w_a;
    logic signed [39:0] w_a40, w_n16, w_n32, w_n64, w_h100, w_n2;

    lre_pkg::t_ctl        r_ctl;
    logic signed [NW-1:0] r_n16, r_n32, r_n64;
    logic [14:0]          r_m;
    logic                 r_band_hi, r_a_hi, r_a_lo;

    always_comb begin
        if (i_d.zero) begin
            w_a = i_d.zneg ? -26'sd5898240 : 26'sd5898240;
        end else begin
            w_a = i_d.ang;
        end
        w_a40  = {{(40 - lre_pkg::ANG_W){w_a[lre_pkg::ANG_W-1]}}, w_a};
        w_n16  = w_a40 + 40'sd1048576;
        w_n32  = 40'sd3 * w_a40 + 40'sd6029312;
        w_n64  = 40'sd425984 - 40'sd3 * w_a40;
        w_h100 = 40'sd100 * w_a40;
        w_n2   = -40'sd112459776 - 40'sd200 * w_a40;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl.valid <= 1'b0;
        end else if (i_adv) begin
            r_ctl     <= i_d.ctl;
            r_n16     <= w_n16[NW-1:0];
            r_n32     <= w_n32[NW-1:0];
            r_n64     <= w_n64[NW-1:0];
            r_m       <= w_n2[30:16];
            r_band_hi <= (w_h100 >= -40'sd57868288);
            r_a_hi    <= (w_a40 > 40'sd131072);
            r_a_lo    <= (w_h100 < -40'sd159449088);
        end
    end

    // Second stage: truncating division and the window checks.
    logic [32:0] w_prod;
    logic [8:0]  w_q;
    logic        w_ok;
    logic [5:0]  w_ring;
    logic [2:0]  n_status;

    always_comb begin
        w_prod = 33'(r_m) * 33'd167773;
        w_q    = w_prod[32:24];
        case (i_line_count)
            lre_pkg::LINES_16: begin
                w_ok   = (r_n16 > -28'sd131072) && (r_n16 < 28'sd2097152);
                w_ring = r_n16[NW-1] ? 6'd0 : r_n16[22:17];
            end
            lre_pkg::LINES_32: begin
                w_ok   = (r_n32 > -28'sd262144) && (r_n32 < 28'sd8388608);
                w_ring = r_n32[NW-1] ? 6'd0 : r_n32[23:18];
            end
            default: begin
                if (r_band_hi) begin
                    w_ok   = (r_n64 > -28'sd65536) && (r_n64 < 28'sd4194304);
                    w_ring = r_n64[NW-1] ? 6'd0 : r_n64[21:16];
                end else begin
                    w_ok   = (w_q <= 9'd31);
                    w_ring = 6'd32 + w_q[5:0];
                end
                w_ok = w_ok && !r_a_hi && !r_a_lo;
            end
        endcase
        if (r_ctl.status != lre_pkg::ST_KEPT) begin
            n_status = r_ctl.status;
        end else if (!w_ok) begin
            n_status = lre_pkg::ST_ELEVATION;
        end else begin
            n_status = lre_pkg::ST_KEPT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_adv) begin
            o_valid  <= r_ctl.valid;
            o_status <= n_status;
            o_keep   <= (n_status == lre_pkg::ST_KEPT);
            o_ring   <= (n_status == lre_pkg::ST_KEPT) ? w_ring : 6'd0;
        end
    end
endmodule

// ===== design/lidar_ring_index_from_elevation.sv =====
// Channel  | Direction | Handshake          | Payload
// request  | in        | i_valid / o_stall  | i_x_coord, i_y_coord, i_z_coord, i_not_finite
// result   | out       | o_valid / i_stall  | o_keep, o_ring, o_status
// config   | in        | i_cfg_we           | i_cfg_idx, i_cfg_data
//
// One request is taken per cycle while the pipeline is not stalled. A request passes
// through 60 register stages: input and square registers, 32 square-root digit cells,
// the range register, 23 CORDIC rotation cells and two mapping registers.
// The whole pipeline advances together; it holds only while a result waits
// under i_stall, and o_stall then holds back the request side.
// Reset is synchronous and active low; it clears the valid bits and loads the
// register defaults.
module lidar_ring_index_from_elevation #(
    parameter int MAX_RINGS = lre_pkg::MAX_RINGS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic signed [31:0]             i_x_coord,
    input  logic signed [31:0]             i_y_coord,
    input  logic signed [31:0]             i_z_coord,
    input  logic                           i_not_finite,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic                           o_keep,
    output logic [5:0]                     o_ring,
    output logic [2:0]                     o_status,
    input  logic                           i_cfg_we,
    input  logic [lre_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [lre_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    // Configuration registers. The user must change them only while the block is idle;
    // the block itself does not enforce this. Every stage reads them directly.
    logic [30:0] r_min_range, r_max_range;
    logic [7:0]  r_line_count;
    logic        r_sensor_model;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_range    <= lre_pkg::MIN_RANGE_RST;
            r_max_range    <= lre_pkg::MAX_RANGE_RST;
            r_line_count   <= lre_pkg::LINE_COUNT_RST;
            r_sensor_model <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                lre_pkg::REG_MIN_RANGE:    r_min_range    <= i_cfg_data[30:0];
                lre_pkg::REG_MAX_RANGE:    r_max_range    <= i_cfg_data[30:0];
                lre_pkg::REG_LINE_COUNT:   r_line_count   <= i_cfg_data[7:0];
                lre_pkg::REG_SENSOR_MODEL: r_sensor_model <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // The pipeline moves unless a finished result is being held.
    logic w_adv;
    assign w_adv   = !(o_valid && i_stall);
    assign o_stall = !w_adv;

    logic w_lines_ok;
    assign w_lines_ok = ((r_line_count == lre_pkg::LINES_16)
                      || (r_line_count == lre_pkg::LINES_32)
                      || (r_line_count == lre_pkg::LINES_64))
                      && (32'(r_line_count) <= 32'(MAX_RINGS));

    // Input register. Early status settles the unsupported and non-finite cases.
    lre_pkg::t_ctl      r_in_ctl, n_in_ctl;
    logic signed [31:0] r_x, r_y, r_z;

    always_comb begin
        n_in_ctl.valid = i_valid;
        if (r_sensor_model || !w_lines_ok) begin
            n_in_ctl.status = lre_pkg::ST_UNSUPPORTED;
        end else if (i_not_finite) begin
            n_in_ctl.status = lre_pkg::ST_NOT_FINITE;
        end else begin
            n_in_ctl.status = lre_pkg::ST_KEPT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_ctl.valid <= 1'b0;
        end else if (w_adv) begin
            r_in_ctl <= n_in_ctl;
            r_x      <= i_x_coord;
            r_y      <= i_y_coord;
            r_z      <= i_z_coord;
        end
    end

    // Squares of the magnitudes, one multiplier each.
    logic [31:0]        w_ax, w_ay;
    lre_pkg::t_ctl      r_sq_ctl;
    logic [63:0]        r_px, r_py;
    logic signed [31:0] r_sq_z;

    assign w_ax = r_x[31] ? 32'(-r_x) : 32'(r_x);
    assign w_ay = r_y[31] ? 32'(-r_y) : 32'(r_y);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_ctl.valid <= 1'b0;
        end else if (w_adv) begin
            r_sq_ctl <= r_in_ctl;
            r_px     <= 64'(w_ax) * 64'(w_ax);
            r_py     <= 64'(w_ay) * 64'(w_ay);
            r_sq_z   <= r_z;
        end
    end

    // Square-root chain: each cell settles one bit of the distance.
    lre_pkg::t_sqrt_stage w_sq [0:lre_pkg::SQRT_STEPS];
    lre_pkg::t_sqrt_stage w_sq_in;

    always_comb begin
        w_sq_in.ctl  = r_sq_ctl;
        w_sq_in.z    = r_sq_z;
        w_sq_in.rad  = r_px + r_py;
        w_sq_in.rem  = '0;
        w_sq_in.root = '0;
    end

    assign w_sq[0] = w_sq_in;

    for (genvar k = 0; k < lre_pkg::SQRT_STEPS; k++) begin : g_sqrt
        lre_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (w_adv),
            .i_d     (w_sq[k]),
            .o_q     (w_sq[k+1])
        );
    end

    // Range check and CORDIC start vector.
    lre_pkg::t_sqrt_stage   w_sq_end;
    lre_pkg::t_cordic_stage r_rng, n_rng;
    logic [31:0]            w_dist;

    assign w_sq_end = w_sq[lre_pkg::SQRT_STEPS];
    assign w_dist   = w_sq_end.root;

    always_comb begin
        n_rng.ctl = w_sq_end.ctl;
        if (w_sq_end.ctl.status == lre_pkg::ST_KEPT
            && (w_dist < 32'(r_min_range) || w_dist > 32'(r_max_range))) begin
            n_rng.ctl.status = lre_pkg::ST_RANGE;
        end
        n_rng.zero = (w_dist == 32'd0);
        n_rng.zneg = w_sq_end.z[31];
        n_rng.xv   = {4'b0000, w_dist, 24'd0};
        n_rng.yv   = {{4{w_sq_end.z[31]}}, w_sq_end.z, 24'd0};
        n_rng.ang  = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rng.ctl.valid <= 1'b0;
        end else if (w_adv) begin
            r_rng <= n_rng;
        end
    end

    // CORDIC chain: cell i rotates by atan(2^-i).
    lre_pkg::t_cordic_stage w_cr [0:lre_pkg::CORDIC_STEPS];
    assign w_cr[0] = r_rng;

    for (genvar i = 0; i < lre_pkg::CORDIC_STEPS; i++) begin : g_cordic
        lre_cordic_cell #(.SHIFT(i)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (w_adv),
            .i_d     (w_cr[i]),
            .o_q     (w_cr[i+1])
        );
    end

    lre_ring_map u_map (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_adv        (w_adv),
        .i_line_count (r_line_count),
        .i_d          (w_cr[lre_pkg::CORDIC_STEPS]),
        .o_valid      (o_valid),
        .o_keep       (o_keep),
        .o_ring       (o_ring),
        .o_status     (o_status)
    );
endmodule

// ===== sim/lidar_ring_index_from_elevation_test.sv =====
`timescale 1ns / 100ps

// Testbench for the lidar ring assignment block.
//
// The stimulus process fills a queue of pending points. A clocked driver takes
// requests from that queue and offers them to the block. At every accepted
// request it computes the expected keep, ring and status with its own
// predictor, and stores them in a result queue. A clocked monitor compares
// each accepted result, field by field, with the oldest entry of that queue.
//
// Both sides idle at random, except during one stretch with no idling at all.
// Registers are written only while the pipeline is empty.
module lidar_ring_index_from_elevation_test;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic               nf;
    } t_point;

    typedef struct {
        logic       keep;
        logic [5:0] ring;
        logic [2:0] status;
    } t_ring_res;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_stall = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [lre_pkg::CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [lre_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;
    t_point drive_pt = '{32'sd0, 32'sd0, 32'sd0, 1'b0};
    logic o_stall;
    logic o_valid;
    logic o_keep;
    logic [5:0] o_ring;
    logic [2:0] o_status;

    // The payload ports follow the point that the driver currently offers.
    wire signed [31:0] i_x_coord = drive_pt.x;
    wire signed [31:0] i_y_coord = drive_pt.y;
    wire signed [31:0] i_z_coord = drive_pt.z;
    wire i_not_finite = drive_pt.nf;

    lidar_ring_index_from_elevation dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_x_coord(i_x_coord), .i_y_coord(i_y_coord),
        .i_z_coord(i_z_coord), .i_not_finite(i_not_finite),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_keep(o_keep), .o_ring(o_ring), .o_status(o_status),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // The predictor keeps its own copy of the registers.
    logic [30:0] min_dist_q = lre_pkg::MIN_RANGE_RST;
    logic [30:0] max_dist_q = lre_pkg::MAX_RANGE_RST;
    logic [7:0]  lines_q = lre_pkg::LINE_COUNT_RST;
    logic        model_q = 1'b0;

    t_point    pend_q[$];
    t_ring_res ring_exp_q[$];
    int  mismatches = 0;
    int  points_in = 0;
    int  results_out = 0;
    int  kept_count = 0;
    bit  hold_send = 1'b0;
    bit  idle_on = 1'b1;

    // Integer square root, floor, of a 64-bit unsigned value.
    function automatic logic [63:0] floor_sqrt(input logic [63:0] s);
        logic [63:0] res;
        logic [63:0] bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > s) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (s >= res + bitv) begin
                s = s - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // Elevation in degrees, Q16.16, by vectoring rotation with a 2^24 prescale.
    function automatic longint elevation_deg(input longint hdist, input longint z);
        longint xv, yv, xs, ys, ang;
        longint steps[23] = '{2949120, 1740967, 919879, 466945, 234379, 117304,
                              58666, 29335, 14668, 7334, 3667, 1833, 917, 458,
                              229, 115, 57, 29, 14, 7, 4, 2, 1};
        ang = 0;
        // A point straight above or below the sensor has no horizontal run.
        if (hdist == 0) return (z < 0) ? -90 * 65536 : 90 * 65536;
        xv = hdist * 16777216;
        yv = z * 16777216;
        for (int i = 0; i < 23; i++) begin
            xs = xv >>> i;
            ys = yv >>> i;
            if (yv >= 0) begin
                xv = xv + ys;
                yv = yv - xs;
                ang = ang + steps[i];
            end else begin
                xv = xv - ys;
                yv = yv + xs;
                ang = ang - steps[i];
            end
        end
        return ang;
    endfunction

    function automatic t_ring_res predict_ring(input t_point p);
        t_ring_res r;
        longint x, y, z, a, ring;
        logic [63:0] sq, hdist;
        bit lines_ok;
        x = p.x;
        y = p.y;
        z = p.z;
        ring = 0;
        r.status = lre_pkg::ST_KEPT;
        lines_ok = (lines_q == lre_pkg::LINES_16 || lines_q == lre_pkg::LINES_32
                    || lines_q == lre_pkg::LINES_64)
                   && lines_q <= 64;
        // An unsupported setup rejects every point before anything else.
        if (model_q != 1'b0 || !lines_ok) begin
            r.status = lre_pkg::ST_UNSUPPORTED;
        end else if (p.nf) begin
            r.status = lre_pkg::ST_NOT_FINITE;
        end else begin
            sq = 64'(x * x) + 64'(y * y);
            hdist = floor_sqrt(sq);
            if (hdist < {33'd0, min_dist_q} || hdist > {33'd0, max_dist_q}) begin
                r.status = lre_pkg::ST_RANGE;
            end else begin
                a = elevation_deg(longint'(hdist), z);
                // Division truncates toward zero, so angles just under the
                // lowest ring still land on ring zero.
                if (lines_q == lre_pkg::LINES_16) begin
                    ring = (a + 16 * 65536) / 131072;
                    if (ring < 0 || ring > 15) r.status = lre_pkg::ST_ELEVATION;
                end else if (lines_q == lre_pkg::LINES_32) begin
                    ring = (3 * a + 92 * 65536) / 262144;
                    if (ring < 0 || ring > 31) r.status = lre_pkg::ST_ELEVATION;
                end else begin
                    if (100 * a >= -883 * 65536)
                        ring = (425984 - 3 * a) / 65536;
                    else
                        ring = 32 + (-1716 * 65536 - 200 * a) / 6553600;
                    if (a > 2 * 65536 || 100 * a < -2433 * 65536 || ring < 0 || ring > 63)
                        r.status = lre_pkg::ST_ELEVATION;
                end
            end
        end
        r.keep = (r.status == lre_pkg::ST_KEPT);
        r.ring = r.keep ? ring[5:0] : 6'd0;
        return r;
    endfunction

    // Request driver: records each accepted point, then offers the next one.
    always @(posedge i_clk) begin : request_driver
        t_point nx;
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                ring_exp_q.insert(ring_exp_q.size(), predict_ring(drive_pt));
                points_in++;
            end
            // A stalled request keeps its payload unchanged.
            if (!i_valid || !o_stall) begin
                if (pend_q.size() > 0 && !hold_send
                    && !(idle_on && $urandom_range(99) < 28)) begin
                    nx = pend_q.pop_front();
                    drive_pt <= nx;
                    i_valid <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: checks against the oldest expectation, then picks a stall.
    always @(posedge i_clk) begin : result_monitor
        t_ring_res e;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                results_out++;
                if (ring_exp_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result keep=%0d ring=%0d status=%0d",
                                 o_keep, o_ring, o_status);
                end else begin
                    e = ring_exp_q.pop_front();
                    if (e.keep) kept_count++;
                    if (o_keep !== e.keep || o_ring !== e.ring || o_status !== e.status) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"result %0d: expected keep=%0d ring=%0d status=%0d,",
                                      " got keep=%0d ring=%0d status=%0d"},
                                     results_out, e.keep, e.ring, e.status,
                                     o_keep, o_ring, o_status);
                    end
                end
            end
            i_stall <= idle_on && ($urandom_range(99) < 28);
        end
    end

    task automatic add_point(input logic [31:0] x, input logic [31:0] y,
                             input logic [31:0] z, input logic nf);
        t_point p;
        p.x = x;
        p.y = y;
        p.z = z;
        p.nf = nf;
        pend_q.insert(pend_q.size(), p);
    endtask

    // Waits until every queued request has been taken and every result checked.
    task automatic drain;
        do @(negedge i_clk);
        while (pend_q.size() != 0 || i_valid || ring_exp_q.size() != 0);
    endtask

    task automatic write_reg(input logic [lre_pkg::CFG_IDX_W-1:0] idx,
                             input logic [30:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            lre_pkg::REG_MIN_RANGE:    min_dist_q = val;
            lre_pkg::REG_MAX_RANGE:    max_dist_q = val;
            lre_pkg::REG_LINE_COUNT:   lines_q = val[7:0];
            lre_pkg::REG_SENSOR_MODEL: model_q = val[0];
            default:                   ;
        endcase
    endtask

    // Mostly points within about 40 m with modest elevation, some raw noise.
    task automatic random_points(input int n);
        int m, zs;
        logic [31:0] x, y, z;
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(9) == 0) begin
                add_point($urandom, $urandom, $urandom, $urandom_range(1));
            end else begin
                m = 65536 * $urandom_range(40);
                x = int'($urandom_range(2 * m + 1)) - m;
                y = int'($urandom_range(2 * m + 1)) - m;
                zs = 65536 * $urandom_range(1, 20);
                z = int'($urandom_range(2 * zs)) - zs;
                add_point(x, y, z, $urandom_range(19) == 0);
            end
        end
    endtask

    initial begin : stimulus
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed points under the reset setup of 64 lines, 3 m to 35 m.
        add_point(32'h7fffffff, 32'h80000000, 32'h7fffffff, 1'b1);
        add_point(32'h7fffffff, 32'h7fffffff, 32'h80000000, 1'b0);
        add_point(32'h80000000, 32'h0, 32'h0, 1'b0);
        add_point(32'h0, 32'h0, 32'h0, 1'b0);
        add_point(196608, 0, 0, 1'b0);
        add_point(196607, 0, 0, 1'b0);
        add_point(0, 2293760, 0, 1'b0);
        add_point(0, 2293761, 0, 1'b0);
        add_point(655360, 0, 655360, 1'b0);
        add_point(655360, 0, 22938, 1'b0);
        add_point(655360, 0, -101580, 1'b0);
        add_point(655360, 0, -155000, 1'b0);
        add_point(655360, 0, -296000, 1'b0);
        add_point(-655360, -655360, -400000, 1'b0);
        add_point(655360, 0, 0, 1'b1);
        random_points(60);

        // Mid-stream, the sender holds off until every result is back.
        repeat (30) @(negedge i_clk);
        hold_send = 1'b1;
        do @(negedge i_clk);
        while (i_valid || ring_exp_q.size() != 0);
        hold_send = 1'b0;
        random_points(30);
        drain();

        write_reg(lre_pkg::REG_LINE_COUNT, lre_pkg::LINES_16);
        write_reg(lre_pkg::REG_MIN_RANGE, 31'd0);
        write_reg(lre_pkg::REG_MAX_RANGE, 31'h7fffffff);
        add_point(0, 0, -65536, 1'b0);
        add_point(0, 0, 0, 1'b0);
        add_point(0, 0, 65536, 1'b0);
        add_point(655360, 0, -190000, 1'b0);
        random_points(100);
        drain();

        // Long stretch with no idling on either side.
        idle_on = 1'b0;
        write_reg(lre_pkg::REG_LINE_COUNT, lre_pkg::LINES_32);
        write_reg(lre_pkg::REG_MIN_RANGE, 31'd65536);
        write_reg(lre_pkg::REG_MAX_RANGE, 31'd1966080);
        random_points(110);
        drain();
        idle_on = 1'b1;

        write_reg(lre_pkg::REG_LINE_COUNT, lre_pkg::LINES_64);
        write_reg(lre_pkg::REG_MIN_RANGE, 31'h7fffffff);
        random_points(20);
        drain();
        write_reg(lre_pkg::REG_MIN_RANGE, 31'd0);
        write_reg(lre_pkg::REG_MAX_RANGE, 31'd3276800);
        random_points(120);
        drain();

        // Unsupported setups reject every point.
        write_reg(lre_pkg::REG_LINE_COUNT, 8'd255);
        random_points(30);
        drain();
        write_reg(lre_pkg::REG_LINE_COUNT, 8'd0);
        random_points(20);
        drain();
        write_reg(lre_pkg::REG_LINE_COUNT, lre_pkg::LINES_64);
        write_reg(lre_pkg::REG_SENSOR_MODEL, 31'd1);
        random_points(30);
        drain();
        write_reg(lre_pkg::REG_SENSOR_MODEL, 31'd0);
        write_reg(lre_pkg::REG_MIN_RANGE, lre_pkg::MIN_RANGE_RST);
        write_reg(lre_pkg::REG_MAX_RANGE, lre_pkg::MAX_RANGE_RST);
        random_points(110);
        drain();

        repeat (80) @(posedge i_clk);
        $display("Checked %0d points (%0d kept) over 16, 32 and 64 lines,",
                 points_in, kept_count);
        $display("range limits at both extremes and unsupported setups; %0d mismatches.",
                 mismatches);
        if (mismatches == 0 && results_out == points_in)
            $display("lidar_ring_index_from_elevation_test: clean");
        else
            $display("lidar_ring_index_from_elevation_test: errors");
        $finish;
    end

    initial begin : watchdog
        #400000;
        $display("timeout with %0d results outstanding", ring_exp_q.size());
        $display("lidar_ring_index_from_elevation_test: errors");
        $finish;
    end

endmodule

// ===== lidar_ring_index_from_elevation.f =====
design/lre_pkg.sv
design/lre_sqrt_cell.sv
design/lre_cordic_cell.sv
design/lre_ring_map.sv
design/lidar_ring_index_from_elevation.sv
sim/lidar_ring_index_from_elevation_test.sv
